// ===== src/z80ipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package z80ipd_pkg;

  typedef enum logic [1:0] {
    IDX_HL = 2'd0,
    IDX_IX = 2'd1,
    IDX_IY = 2'd2
  } index_e;

  typedef enum logic [2:0] {
    TBL_MAIN = 3'd0,
    TBL_CB   = 3'd1,
    TBL_ED   = 3'd2,
    TBL_XCB  = 3'd3,
    TBL_LONE = 3'd4
  } table_e;

  localparam logic [7:0] OP_DD    = 8'hDD;
  localparam logic [7:0] OP_FD    = 8'hFD;
  localparam logic [7:0] OP_ED    = 8'hED;
  localparam logic [7:0] OP_CB    = 8'hCB;
  localparam logic [7:0] OP_HALT  = 8'h76;
  localparam logic [7:0] OP_Q_BIT = 8'h08;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [15:0] byte_address;
    logic        start_new;
  } req_t;

  typedef struct packed {
    logic [15:0] address;
    logic [2:0]  length;
    index_e      index_kind;
    table_e      table_kind;
    logic [7:0]  opcode;
    logic        has_disp;
    logic [7:0]  disp;
    logic [1:0]  imm_bytes;
    logic [15:0] imm;
    logic        target_valid;
    logic [15:0] target;
    logic        undef_ed;
  } res_t;

  // per-opcode shape: total length and which extra bytes follow
  typedef struct packed {
    logic [2:0] len;
    logic       dsp;
    logic [1:0] imm;
    logic       rel;
  } cls_t;

  function automatic cls_t classify(input table_e tbl, input logic pre,
                                    input logic [7:0] op);
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    cls_t       c;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    c = '0;
    case (tbl)
      TBL_CB: begin
        c.len = 3'd2;
      end
      TBL_XCB: begin
        c.dsp = 1'b1;
        c.len = 3'd4;
      end
      TBL_ED: begin
        if (x == 2'd1 && z == 3'd3) begin
          c.imm = 2'd2;
          c.len = 3'd4;
        end else begin
          c.len = 3'd2;
        end
      end
      default: begin
        case (x)
          2'd0: begin
            if (z == 3'd0 && y >= 3'd2) begin
              c.dsp = 1'b1;
              c.rel = 1'b1;
            end else if (z == 3'd1 && (op & OP_Q_BIT) == 8'h00) begin
              c.imm = 2'd2;
            end else if (z == 3'd2 && y >= 3'd4) begin
              c.imm = 2'd2;
            end else if ((z == 3'd4 || z == 3'd5) && y == 3'd6 && pre) begin
              c.dsp = 1'b1;
            end else if (z == 3'd6) begin
              c.imm = 2'd1;
              if (y == 3'd6 && pre) c.dsp = 1'b1;
            end
          end
          2'd1: begin
            if (op != OP_HALT && (y == 3'd6 || z == 3'd6) && pre) c.dsp = 1'b1;
          end
          2'd2: begin
            if (z == 3'd6 && pre) c.dsp = 1'b1;
          end
          default: begin
            if (z == 3'd2 || z == 3'd4) begin
              c.imm = 2'd2;
            end else if (z == 3'd3) begin
              if (y == 3'd0) c.imm = 2'd2;
              else if (y == 3'd2 || y == 3'd3) c.imm = 2'd1;
            end else if (z == 3'd5 && (op & OP_Q_BIT) != 8'h00) begin
              c.imm = 2'd2;
            end else if (z == 3'd6) begin
              c.imm = 2'd1;
            end
          end
        endcase
        c.len = 3'd1 + {2'b00, pre} + {2'b00, c.dsp} + {1'b0, c.imm};
      end
    endcase
    return c;
  endfunction

  // ED opcodes outside the documented set act as two-byte no-ops
  function automatic logic ed_undefined(input logic [7:0] op);
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic       u;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    if (x == 2'd1) u = (z == 3'd7 && y >= 3'd6);
    else if (x == 2'd2 && z <= 3'd3 && y >= 3'd4) u = 1'b0;
    else u = 1'b1;
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/z80ipd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module z80ipd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  z80ipd_pkg::req_t   req_i,
  output logic               valid_o,
  output z80ipd_pkg::req_t   req_o,
  input  logic               take_i
);

  logic             valid_q;
  z80ipd_pkg::req_t req_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/z80ipd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module z80ipd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  z80ipd_pkg::req_t   req_i,
  output logic               emit_o,
  output z80ipd_pkg::res_t   res_o
);

  // instruction in progress
  logic [1:0]          pos_q;
  logic [2:0]          exp_q, exp_d;
  z80ipd_pkg::index_e  idx_q, idx_d;
  z80ipd_pkg::table_e  tbl_q, tbl_d;
  logic [7:0]          op_q, op_d;
  logic [7:0]          disp_q, disp_d;
  logic [7:0]          imml_q, imml_d;
  logic [15:0]         addr_q, addr_d;

  logic [2:0]          pos_d;
  logic [1:0]          n;
  logic [7:0]          b;
  logic                is_pfx, first, lone, done, opos;
  z80ipd_pkg::table_e  new_tbl;
  z80ipd_pkg::cls_t    cls_new, cls_held, cls_out;
  logic [15:0]         target;

  assign n       = req_i.start_new ? 2'd0 : pos_q;
  assign b       = req_i.code_byte;
  assign is_pfx  = (b == z80ipd_pkg::OP_DD) || (b == z80ipd_pkg::OP_FD) ||
                   (b == z80ipd_pkg::OP_ED);
  // DD/FD prefix followed by another prefix or ED: the first one stands alone
  assign lone    = (n != 2'd0) && (exp_q == 3'd0) && (tbl_q != z80ipd_pkg::TBL_ED) && is_pfx;
  assign first   = (n == 2'd0) || lone;
  assign new_tbl = (n != 2'd0 && tbl_q == z80ipd_pkg::TBL_ED) ? z80ipd_pkg::TBL_ED
                                                                : z80ipd_pkg::TBL_MAIN;
  assign cls_new  = z80ipd_pkg::classify(new_tbl,
                                         (n != 2'd0) && (idx_q != z80ipd_pkg::IDX_HL), b);
  assign cls_held = z80ipd_pkg::classify(tbl_q, idx_q != z80ipd_pkg::IDX_HL, op_q);
  assign opos     = (tbl_q == z80ipd_pkg::TBL_ED) || (idx_q != z80ipd_pkg::IDX_HL);

  always_comb begin
    addr_d = addr_q;
    idx_d  = idx_q;
    tbl_d  = tbl_q;
    op_d   = op_q;
    disp_d = disp_q;
    imml_d = imml_q;
    exp_d  = exp_q;
    pos_d  = {1'b0, n} + 3'd1;
    if (first) begin
      addr_d = req_i.byte_address;
      idx_d  = z80ipd_pkg::IDX_HL;
      tbl_d  = z80ipd_pkg::TBL_MAIN;
      op_d   = 8'h00;
      disp_d = 8'h00;
      imml_d = 8'h00;
      exp_d  = 3'd0;
      pos_d  = 3'd1;
      case (b)
        z80ipd_pkg::OP_DD: idx_d = z80ipd_pkg::IDX_IX;
        z80ipd_pkg::OP_FD: idx_d = z80ipd_pkg::IDX_IY;
        z80ipd_pkg::OP_ED: tbl_d = z80ipd_pkg::TBL_ED;
        z80ipd_pkg::OP_CB: begin
          tbl_d = z80ipd_pkg::TBL_CB;
          exp_d = 3'd2;
        end
        default: begin
          op_d  = b;
          exp_d = cls_new.len;
        end
      endcase
    end else if (exp_q == 3'd0) begin
      // opcode byte after a prefix
      if (tbl_q == z80ipd_pkg::TBL_ED) begin
        op_d  = b;
        exp_d = cls_new.len;
      end else if (b == z80ipd_pkg::OP_CB) begin
        tbl_d = z80ipd_pkg::TBL_XCB;
        exp_d = 3'd4;
      end else begin
        op_d  = b;
        tbl_d = z80ipd_pkg::TBL_MAIN;
        exp_d = cls_new.len;
      end
    end else begin
      // operand bytes
      if (tbl_q == z80ipd_pkg::TBL_XCB) begin
        if (n == 2'd2) disp_d = b;
        else op_d = b;
      end else if (tbl_q == z80ipd_pkg::TBL_CB) begin
        op_d = b;
      end else if (cls_held.dsp && {1'b0, n} == 3'd1 + {2'b00, opos}) begin
        disp_d = b;
      end else if ({1'b0, n} == 3'd1 + {2'b00, opos} + {2'b00, cls_held.dsp}) begin
        imml_d = b;
      end
    end
  end

  assign done    = !lone && (exp_d != 3'd0) && (pos_d >= exp_d);
  assign emit_o  = lone || done;
  assign cls_out = z80ipd_pkg::classify(tbl_d, idx_d != z80ipd_pkg::IDX_HL, op_d);
  assign target  = addr_d + {13'd0, cls_out.len} + {{8{disp_d[7]}}, disp_d};

  always_comb begin
    res_o = '0;
    if (lone) begin
      res_o.address    = addr_q;
      res_o.length     = 3'd1;
      res_o.index_kind = idx_q;
      res_o.table_kind = z80ipd_pkg::TBL_LONE;
      res_o.opcode     = (idx_q == z80ipd_pkg::IDX_IY) ? z80ipd_pkg::OP_FD
                                                       : z80ipd_pkg::OP_DD;
    end else begin
      res_o.address      = addr_d;
      res_o.length       = cls_out.len;
      res_o.index_kind   = idx_d;
      res_o.table_kind   = tbl_d;
      res_o.opcode       = op_d;
      res_o.has_disp     = cls_out.dsp;
      res_o.disp         = cls_out.dsp ? disp_d : 8'h00;
      res_o.imm_bytes    = cls_out.imm;
      case (cls_out.imm)
        2'd0:    res_o.imm = 16'h0000;
        2'd1:    res_o.imm = {8'h00, b};
        default: res_o.imm = {b, imml_d};
      endcase
      res_o.target_valid = cls_out.rel;
      res_o.target       = cls_out.rel ? target : 16'h0000;
      res_o.undef_ed     = (tbl_d == z80ipd_pkg::TBL_ED) ? z80ipd_pkg::ed_undefined(op_d)
                                                         : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      exp_q  <= 3'd0;
      idx_q  <= z80ipd_pkg::IDX_HL;
      tbl_q  <= z80ipd_pkg::TBL_MAIN;
      op_q   <= 8'h00;
      disp_q <= 8'h00;
      imml_q <= 8'h00;
      addr_q <= 16'h0000;
    end else if (fire_i) begin
      pos_q  <= done ? 2'd0 : pos_d[1:0];
      exp_q  <= done ? 3'd0 : exp_d;
      idx_q  <= idx_d;
      tbl_q  <= tbl_d;
      op_q   <= op_d;
      disp_q <= disp_d;
      imml_q <= imml_d;
      addr_q <= addr_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != 3'd0 |-> {1'b0, pos_q} < exp_q)
    else $error("byte position reached expected length without completing");

  a_unknown_len_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q == 3'd0 && pos_q != 2'd0) |-> pos_q == 2'd1)
    else $error("length still unknown past the prefix byte");

  a_branch_has_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && emit_o && res_o.target_valid) |->
      (res_o.has_disp && res_o.table_kind == z80ipd_pkg::TBL_MAIN))
    else $error("relative branch without displacement");
`endif

endmodule

`default_nettype wire

// ===== src/z80ipd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module z80ipd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  z80ipd_pkg::res_t   res_i,
  output logic               can_load_o,
  output logic               valid_o,
  input  logic               ready_i,
  output z80ipd_pkg::res_t   res_o
);

  logic             valid_q;
  z80ipd_pkg::res_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/z80_instruction_predecoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path: a byte accepted into the input register is decoded from it, and its result is loaded
//   into the result register that drives out_valid_o; a stalled result register delays this.
// Throughput: one code byte per cycle unless a result is blocked at the output; the input
//   register and the result register let a byte enter while the previous result still waits.
// Reset: rst_ni (async, active low) empties both registers and drops any partial instruction.
module z80_instruction_predecoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        code_byte_i,
  input  logic [15:0]       byte_address_i,
  input  logic              start_new_i,
  // instruction result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       instr_address_o,
  output logic [2:0]        instr_length_o,
  output logic [1:0]        index_kind_o,
  output logic [2:0]        table_kind_o,
  output logic [7:0]        opcode_byte_o,
  output logic              has_displacement_o,
  output logic signed [7:0] displacement_o,
  output logic [1:0]        immediate_bytes_o,
  output logic [15:0]       immediate_o,
  output logic              target_valid_o,
  output logic [15:0]       branch_target_o,
  output logic              undefined_ed_o
);

  z80ipd_pkg::req_t in_req, req;
  z80ipd_pkg::res_t dec_res, out_res;
  logic             in_vld;
  logic             emit;
  logic             out_can;
  logic             fire;

  assign in_req.code_byte    = code_byte_i;
  assign in_req.byte_address = byte_address_i;
  assign in_req.start_new    = start_new_i;

  // A held byte moves into the decoder when it yields no result or the
  // result register has room; bytes that only extend an instruction never stall.
  assign fire = in_vld && (!emit || out_can);

  z80ipd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req),
    .valid_o (in_vld),
    .req_o   (req),
    .take_i  (fire)
  );

  // byte position, prefix/table tracking and field extraction
  z80ipd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req),
    .emit_o (emit),
    .res_o  (dec_res)
  );

  z80ipd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && emit),
    .res_i      (dec_res),
    .can_load_o (out_can),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .res_o      (out_res)
  );

  assign instr_address_o    = out_res.address;
  assign instr_length_o     = out_res.length;
  assign index_kind_o       = out_res.index_kind;
  assign table_kind_o       = out_res.table_kind;
  assign opcode_byte_o      = out_res.opcode;
  assign has_displacement_o = out_res.has_disp;
  assign displacement_o     = $signed(out_res.disp);
  assign immediate_bytes_o  = out_res.imm_bytes;
  assign immediate_o        = out_res.imm;
  assign target_valid_o     = out_res.target_valid;
  assign branch_target_o    = out_res.target;
  assign undefined_ed_o     = out_res.undef_ed;

`ifndef NO_ASSERTIONS
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_valid_o)
    else $error("decoded result did not reach the result register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld && out_valid_o && !out_ready_i))
    else $error("byte request refused without a blocked result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // Longest run of cycles with no handshake on either side before we give up.
  // The longest legal request gap and result stall plus the decode path stay far below it.
  localparam int IDLE_LIMIT = 200;
  // Cycles to wait after the last expected record, in case a stray record shows up.
  localparam int TAIL_CYCLES = 20;
  localparam int DIRECTED_BYTES = 26;
  localparam int RANDOM_BYTES = 650;
  localparam int PRINT_CAP = 100;

  // One byte request: code byte, its address, and the restart flag.
  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] addr;
    logic        start;
  } fetch_t;

  // How an opcode extends: total length, displacement byte, immediate count, relative.
  typedef struct packed {
    logic [2:0] len;
    logic       has_disp;
    logic [1:0] imm_n;
    logic       is_rel;
  } shape_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        code_byte_i = 8'h00;
  logic [15:0]       byte_address_i = 16'h0000;
  logic              start_new_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [15:0]       instr_address_o;
  logic [2:0]        instr_length_o;
  logic [1:0]        index_kind_o;
  logic [2:0]        table_kind_o;
  logic [7:0]        opcode_byte_o;
  logic              has_displacement_o;
  logic signed [7:0] displacement_o;
  logic [1:0]        immediate_bytes_o;
  logic [15:0]       immediate_o;
  logic              target_valid_o;
  logic [15:0]       branch_target_o;
  logic              undefined_ed_o;

  z80_instruction_predecoder_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .code_byte_i        (code_byte_i),
    .byte_address_i     (byte_address_i),
    .start_new_i        (start_new_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .instr_address_o    (instr_address_o),
    .instr_length_o     (instr_length_o),
    .index_kind_o       (index_kind_o),
    .table_kind_o       (table_kind_o),
    .opcode_byte_o      (opcode_byte_o),
    .has_displacement_o (has_displacement_o),
    .displacement_o     (displacement_o),
    .immediate_bytes_o  (immediate_bytes_o),
    .immediate_o        (immediate_o),
    .target_valid_o     (target_valid_o),
    .branch_target_o    (branch_target_o),
    .undefined_ed_o     (undefined_ed_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  fetch_t           fetch_queue[$];   // byte requests not yet offered
  z80ipd_pkg::res_t want_instrs[$];   // decoded instructions not yet seen at the output
  logic [15:0]      fetch_pc = 16'h0000;
  int               mismatches = 0;

  // Decoder state, mirrors what the block must hold between bytes.
  int                 dec_pos = 0;      // bytes taken of the current instruction
  int                 dec_len = 0;      // 0 while the length is still unknown
  z80ipd_pkg::index_e dec_index = z80ipd_pkg::IDX_HL;
  z80ipd_pkg::table_e dec_table = z80ipd_pkg::TBL_MAIN;
  logic [7:0]         dec_opcode = 8'h00;
  logic [7:0]         dec_disp = 8'h00;
  logic [7:0]         dec_imm_lo = 8'h00;
  logic [15:0]        dec_start = 16'h0000;

  // Handshake flags sampled at the rising edge, read by the falling-edge drivers.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;
  int   idle_cycles = 0;

  // Opcode field rules: x = op[7:6], y = op[5:3], z = op[2:0].
  function automatic shape_t opcode_shape(input z80ipd_pkg::table_e tbl, input logic indexed,
                                          input logic [7:0] op);
    shape_t     s;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    s = '0;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    if (tbl == z80ipd_pkg::TBL_CB) begin
      s.len = 3'd2;
      return s;
    end
    if (tbl == z80ipd_pkg::TBL_XCB) begin
      s.has_disp = 1'b1;
      s.len = 3'd4;
      return s;
    end
    if (tbl == z80ipd_pkg::TBL_ED) begin
      // only ED 43/53/63/73/4B/5B/6B/7B carry a 16-bit address
      s.imm_n = (x == 2'd1 && z == 3'd3) ? 2'd2 : 2'd0;
      s.len = 3'd2 + 3'(s.imm_n);
      return s;
    end
    case (x)
      2'd0: begin
        case (z)
          3'd0: if (y >= 3'd2) begin
            // DJNZ, JR, JR cc
            s.has_disp = 1'b1;
            s.is_rel = 1'b1;
          end
          3'd1: if (!op[3]) s.imm_n = 2'd2;
          3'd2: if (y >= 3'd4) s.imm_n = 2'd2;
          3'd4, 3'd5: if (y == 3'd6 && indexed) s.has_disp = 1'b1;
          3'd6: begin
            s.imm_n = 2'd1;
            if (y == 3'd6 && indexed) s.has_disp = 1'b1;
          end
          default: ;
        endcase
      end
      2'd1: begin
        // HALT keeps no displacement even behind a prefix
        if (op != z80ipd_pkg::OP_HALT && (y == 3'd6 || z == 3'd6) && indexed)
          s.has_disp = 1'b1;
      end
      2'd2: begin
        if (z == 3'd6 && indexed) s.has_disp = 1'b1;
      end
      default: begin
        case (z)
          3'd2, 3'd4: s.imm_n = 2'd2;
          3'd3: begin
            if (y == 3'd0) s.imm_n = 2'd2;
            else if (y == 3'd2 || y == 3'd3) s.imm_n = 2'd1;
          end
          3'd5: if (op[3]) s.imm_n = 2'd2;
          3'd6: s.imm_n = 2'd1;
          default: ;
        endcase
      end
    endcase
    s.len = 3'd1 + 3'(indexed) + 3'(s.has_disp) + 3'(s.imm_n);
    return s;
  endfunction

  // Documented ED space: x=1 except 77/7F, and the block ops A0..A3, A8..AB, B0..B3, B8..BB.
  function automatic logic ed_hole(input logic [7:0] op);
    if (op[7:6] == 2'd1) return op[2:0] == 3'd7 && op[5:3] >= 3'd6;
    if (op[7:6] == 2'd2) return !(op[2:0] <= 3'd3 && op[5:3] >= 3'd4);
    return 1'b1;
  endfunction

  // Opens a new instruction; returns 1 when the byte is already a whole instruction.
  function automatic bit begin_instr(input logic [7:0] b, input logic [15:0] a);
    shape_t s;
    dec_start = a;
    dec_index = z80ipd_pkg::IDX_HL;
    dec_table = z80ipd_pkg::TBL_MAIN;
    dec_opcode = 8'h00;
    dec_disp = 8'h00;
    dec_imm_lo = 8'h00;
    dec_len = 0;
    dec_pos = 1;
    case (b)
      z80ipd_pkg::OP_DD: dec_index = z80ipd_pkg::IDX_IX;
      z80ipd_pkg::OP_FD: dec_index = z80ipd_pkg::IDX_IY;
      z80ipd_pkg::OP_ED: dec_table = z80ipd_pkg::TBL_ED;
      z80ipd_pkg::OP_CB: begin
        dec_table = z80ipd_pkg::TBL_CB;
        dec_len = 2;
      end
      default: begin
        dec_opcode = b;
        s = opcode_shape(z80ipd_pkg::TBL_MAIN, 1'b0, b);
        dec_len = s.len;
      end
    endcase
    return dec_len == 1;
  endfunction

  // Feeds one accepted byte request to the decoder and queues any finished instruction.
  task automatic decode_byte(input logic [7:0] b, input logic [15:0] a, input logic st);
    int               n;
    int               opos;
    shape_t           s;
    z80ipd_pkg::res_t r;
    logic [15:0]      sdisp;
    n = st ? 0 : dec_pos;
    if (n == 0) begin
      if (!begin_instr(b, a)) return;
    end else if (dec_len == 0) begin
      if (dec_table == z80ipd_pkg::TBL_ED) begin
        dec_opcode = b;
        s = opcode_shape(z80ipd_pkg::TBL_ED, 1'b0, b);
        dec_len = s.len;
        dec_pos = n + 1;
      end else if (b == z80ipd_pkg::OP_DD || b == z80ipd_pkg::OP_FD ||
                   b == z80ipd_pkg::OP_ED) begin
        // prefix followed by another prefix or ED: the first one stands alone
        r = '0;
        r.address = dec_start;
        r.length = 3'd1;
        r.index_kind = dec_index;
        r.table_kind = z80ipd_pkg::TBL_LONE;
        r.opcode = (dec_index == z80ipd_pkg::IDX_IY) ? z80ipd_pkg::OP_FD : z80ipd_pkg::OP_DD;
        want_instrs.push_back(r);
        void'(begin_instr(b, a));
        return;
      end else if (b == z80ipd_pkg::OP_CB) begin
        dec_table = z80ipd_pkg::TBL_XCB;
        dec_len = 4;
        dec_pos = n + 1;
      end else begin
        dec_opcode = b;
        dec_table = z80ipd_pkg::TBL_MAIN;
        s = opcode_shape(z80ipd_pkg::TBL_MAIN, dec_index != z80ipd_pkg::IDX_HL, b);
        dec_len = s.len;
        dec_pos = n + 1;
      end
    end else begin
      if (dec_table == z80ipd_pkg::TBL_XCB) begin
        // DD CB d op: displacement comes before the opcode
        if (n == 2) dec_disp = b;
        else dec_opcode = b;
      end else if (dec_table == z80ipd_pkg::TBL_CB) begin
        dec_opcode = b;
      end else begin
        opos = (dec_table == z80ipd_pkg::TBL_ED || dec_index != z80ipd_pkg::IDX_HL) ? 1 : 0;
        s = opcode_shape(dec_table, dec_index != z80ipd_pkg::IDX_HL, dec_opcode);
        if (s.has_disp && n == opos + 1) dec_disp = b;
        else if (n == opos + 1 + int'(s.has_disp)) dec_imm_lo = b;
      end
      dec_pos = n + 1;
    end

    if (dec_len == 0 || dec_pos < dec_len) return;

    s = opcode_shape(dec_table, dec_index != z80ipd_pkg::IDX_HL, dec_opcode);
    sdisp = {{8{dec_disp[7]}}, dec_disp};
    r = '0;
    r.address = dec_start;
    r.length = s.len;
    r.index_kind = dec_index;
    r.table_kind = dec_table;
    r.opcode = dec_opcode;
    r.has_disp = s.has_disp;
    r.disp = s.has_disp ? dec_disp : 8'h00;
    r.imm_bytes = s.imm_n;
    case (s.imm_n)
      2'd1: r.imm = {8'h00, b};
      2'd2: r.imm = {b, dec_imm_lo};
      default: r.imm = 16'h0000;
    endcase
    r.target_valid = s.is_rel;
    r.target = s.is_rel ? dec_start + 16'(s.len) + sdisp : 16'h0000;
    r.undef_ed = (dec_table == z80ipd_pkg::TBL_ED) ? ed_hole(dec_opcode) : 1'b0;
    want_instrs.push_back(r);
    dec_pos = 0;
    dec_len = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Puts an instruction's bytes in the request queue at consecutive addresses.
  // With scramble set, the trailing bytes carry junk addresses, which must be ignored.
  task automatic push_seq(input logic [7:0] seq[$], input logic st, input bit scramble);
    fetch_t f;
    for (int i = 0; i < seq.size(); i++) begin
      f.code = seq[i];
      f.addr = (scramble && i != 0) ? 16'($urandom) : fetch_pc;
      f.start = (i == 0) ? st : 1'b0;
      fetch_queue.push_back(f);
      fetch_pc++;
    end
  endtask

  // Per-request wait, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Leading byte for a random instruction, weighted toward prefixes and branches.
  function automatic logic [7:0] pick_lead();
    case ($urandom_range(0, 15))
      0, 1: return z80ipd_pkg::OP_DD;
      2, 3: return z80ipd_pkg::OP_FD;
      4, 5: return z80ipd_pkg::OP_ED;
      6: return z80ipd_pkg::OP_CB;
      7: return {2'b00, 3'($urandom_range(2, 7)), 3'b000};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds one well-formed byte sequence; a prefix chain may hold lone prefixes.
  task automatic build_instr(output logic [7:0] seq[$]);
    logic [7:0] lead;
    logic [7:0] nxt;
    shape_t     s;
    bit         done;
    seq = {};
    lead = pick_lead();
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      if (lead == z80ipd_pkg::OP_DD || lead == z80ipd_pkg::OP_FD) begin
        case ($urandom_range(0, 7))
          0: begin
            if ($urandom_range(0, 2) == 0) nxt = z80ipd_pkg::OP_ED;
            else nxt = $urandom_range(0, 1) ? z80ipd_pkg::OP_DD : z80ipd_pkg::OP_FD;
          end
          1: nxt = z80ipd_pkg::OP_CB;
          default: nxt = 8'($urandom_range(0, 255));
        endcase
        seq.push_back(lead);
        if (nxt == z80ipd_pkg::OP_DD || nxt == z80ipd_pkg::OP_FD ||
            nxt == z80ipd_pkg::OP_ED) begin
          lead = nxt;
          done = 1'b0;
        end else if (nxt == z80ipd_pkg::OP_CB) begin
          seq.push_back(z80ipd_pkg::OP_CB);
          repeat (2) seq.push_back(8'($urandom_range(0, 255)));
        end else begin
          seq.push_back(nxt);
          s = opcode_shape(z80ipd_pkg::TBL_MAIN, 1'b1, nxt);
          repeat (int'(s.len) - 2) seq.push_back(8'($urandom_range(0, 255)));
        end
      end else if (lead == z80ipd_pkg::OP_ED) begin
        // favor the ED forms that carry a 16-bit immediate
        nxt = ($urandom_range(0, 3) == 0) ? {2'b01, 3'($urandom_range(0, 7)), 3'b011}
                                          : 8'($urandom_range(0, 255));
        seq.push_back(z80ipd_pkg::OP_ED);
        seq.push_back(nxt);
        s = opcode_shape(z80ipd_pkg::TBL_ED, 1'b0, nxt);
        repeat (int'(s.len) - 2) seq.push_back(8'($urandom_range(0, 255)));
      end else if (lead == z80ipd_pkg::OP_CB) begin
        seq.push_back(z80ipd_pkg::OP_CB);
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq.push_back(lead);
        s = opcode_shape(z80ipd_pkg::TBL_MAIN, 1'b0, lead);
        repeat (int'(s.len) - 1) seq.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0] seq[$];
    logic [7:0] noise[$];
    bit         resync;
    logic       st;

    // Directed part: branch wrap both ways, prefix corner cases, restart mid-instruction.
    fetch_pc = 16'hFFFE;
    push_seq('{8'h18, 8'h7F}, 1'b1, 1'b0);               // JR +127 wrapping past FFFF
    push_seq('{8'h10, 8'h80}, 1'b0, 1'b0);               // DJNZ -128 wrapping below 0
    push_seq('{8'hFF}, 1'b0, 1'b0);                      // RST 38, single byte
    // LD (IX-128),FF, junk addresses
    push_seq('{z80ipd_pkg::OP_DD, 8'h36, 8'h80, 8'hFF}, 1'b0, 1'b1);
    // indexed CB
    push_seq('{z80ipd_pkg::OP_FD, z80ipd_pkg::OP_CB, 8'h7F, 8'hFE}, 1'b0, 1'b0);
    // lone DD, then LD IY,nn
    push_seq('{z80ipd_pkg::OP_DD, z80ipd_pkg::OP_FD, 8'h21, 8'h34, 8'h12}, 1'b0, 1'b0);
    push_seq('{z80ipd_pkg::OP_ED, 8'h00}, 1'b0, 1'b0);   // undefined ED
    // HALT behind a prefix
    push_seq('{z80ipd_pkg::OP_DD, z80ipd_pkg::OP_HALT}, 1'b0, 1'b0);
    push_seq('{8'h01, 8'h34}, 1'b0, 1'b0);               // LD BC,nn cut short...
    push_seq('{8'h3E, 8'h55}, 1'b1, 1'b0);               // ...by a restart request

    // Random part: mostly whole instructions, some truncated ones and loose noise.
    resync = 1'b0;
    while (fetch_queue.size() < DIRECTED_BYTES + RANDOM_BYTES) begin
      build_instr(seq);
      st = resync || ($urandom_range(0, 7) == 0);
      resync = 1'b0;
      if (seq.size() > 1 && $urandom_range(0, 11) == 0) begin
        seq = seq[0:$urandom_range(0, seq.size() - 2)];
        resync = ($urandom_range(0, 3) != 0);
      end
      push_seq(seq, st, $urandom_range(0, 15) == 0);
      if ($urandom_range(0, 19) == 0) begin
        noise = {};
        repeat ($urandom_range(1, 3)) noise.push_back(8'($urandom_range(0, 255)));
        push_seq(noise, 1'($urandom_range(0, 1)), 1'b0);
        resync = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) == 0) fetch_pc = 16'($urandom);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (fetch_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (want_instrs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Rising edge: note handshakes and run the decoder on every accepted byte request.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) decode_byte(code_byte_i, byte_address_i, start_new_i);
  end

  // Request driver: holds a pending request until it is taken, then waits its gap.
  always @(negedge clk_i) begin : drive_fetch
    fetch_t f;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (fetch_queue.size() != 0) begin
        f = fetch_queue.pop_front();
        code_byte_i <= f.code;
        byte_address_i <= f.addr;
        start_new_i <= f.start;
        in_valid_i <= 1'b1;
        in_gap = draw_wait(calm_in);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: a random stall follows every accepted record.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_stall = draw_wait(calm_out);
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: every accepted record must match the oldest decoded instruction.
  always @(posedge clk_i) begin : check_instr
    z80ipd_pkg::res_t want;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_instrs.size() == 0) begin
        report_mismatch("record with nothing pending, address", instr_address_o, 16'h0000);
      end else begin
        want = want_instrs.pop_front();
        if (instr_address_o !== want.address)
          report_mismatch("instr_address", instr_address_o, want.address);
        if (instr_length_o !== want.length)
          report_mismatch("instr_length", 16'(instr_length_o), 16'(want.length));
        if (index_kind_o !== want.index_kind)
          report_mismatch("index_kind", 16'(index_kind_o), 16'(want.index_kind));
        if (table_kind_o !== want.table_kind)
          report_mismatch("table_kind", 16'(table_kind_o), 16'(want.table_kind));
        if (opcode_byte_o !== want.opcode)
          report_mismatch("opcode_byte", 16'(opcode_byte_o), 16'(want.opcode));
        if (has_displacement_o !== want.has_disp)
          report_mismatch("has_displacement", 16'(has_displacement_o), 16'(want.has_disp));
        if (displacement_o !== want.disp)
          report_mismatch("displacement", {8'h00, displacement_o}, {8'h00, want.disp});
        if (immediate_bytes_o !== want.imm_bytes)
          report_mismatch("immediate_bytes", 16'(immediate_bytes_o), 16'(want.imm_bytes));
        if (immediate_o !== want.imm)
          report_mismatch("immediate", immediate_o, want.imm);
        if (target_valid_o !== want.target_valid)
          report_mismatch("target_valid", 16'(target_valid_o), 16'(want.target_valid));
        if (branch_target_o !== want.target)
          report_mismatch("branch_target", branch_target_o, want.target);
        if (undefined_ed_o !== want.undef_ed)
          report_mismatch("undefined_ed", 16'(undefined_ed_o), 16'(want.undef_ed));
      end
    end
  end

  // Watchdog: too long with no handshake on either side means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
src/z80ipd_pkg.sv
src/z80ipd_in_reg.sv
src/z80ipd_decode.sv
src/z80ipd_out_reg.sv
src/z80_instruction_predecoder_core.sv
tb/tb_top.sv
